>>> sv/ffa_pkg.sv
package ffa_pkg;

  localparam int ADDR_W         = 16;
  localparam int SIZE_W         = 17;
  localparam int NEED_W         = 18;
  localparam int BYTES_W        = 23;
  localparam int LOG_UNIT_BYTES = 6;
  localparam int LOG_CHUNK      = 10;
  localparam int MEM_DEPTH      = 1 << ADDR_W;

  localparam logic [NEED_W-1:0] WALK_LIMIT  = NEED_W'(2 * MEM_DEPTH + 8);
  localparam logic [NEED_W-1:0] SPACE_LIMIT = NEED_W'(65535);

  localparam logic [1:0] CFG_MIN_CHUNK = 2'd0;
  localparam logic [1:0] CFG_MAX_TOTAL = 2'd1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOMEM   = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  typedef enum logic [4:0] {
    CMD_NONE, CMD_CLEAR, CMD_LATCH, CMD_A_HEAD, CMD_A_LOAD, CMD_A_RD, CMD_A_EVAL,
    CMD_A_SPLIT, CMD_G_SIZE, CMD_G_CHECK, CMD_A_REHEAD, CMD_F_RD, CMD_F_CHK,
    CMD_I_START, CMD_I_RD, CMD_I_EVAL, CMD_I_RBP, CMD_I_RNX, CMD_I_RP,
    CMD_I_MERGE, CMD_I_LINK, CMD_OOM, CMD_BADF, CMD_DONE
  } cmd_e;

  typedef struct packed {
    logic clr_last;
    logic req_free;
    logic addr_null;
    logic is_free;
    logic fit;
    logic exact;
    logic at_rover;
    logic guard_over;
    logic taken_full;
    logic grow_over;
    logic range_bad;
    logic hdr_set;
    logic ins_stop;
    logic ins_over;
  } stat_t;

endpackage

>>> sv/ffa_ctrl.sv
module ffa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ffa_pkg::stat_t stat_i,
  output ffa_pkg::cmd_e cmd_o,
  output logic          busy_o,
  output logic          done_o
);
  import ffa_pkg::*;

  typedef enum logic [22:0] {
    S_CLEAR    = 23'd1,
    S_IDLE     = 23'd2,
    S_A_HEAD   = 23'd4,
    S_A_LOAD   = 23'd8,
    S_A_RD     = 23'd16,
    S_A_EVAL   = 23'd32,
    S_A_SPLIT  = 23'd64,
    S_G_SIZE   = 23'd128,
    S_G_CHECK  = 23'd256,
    S_A_REHEAD = 23'd512,
    S_F_RD     = 23'd1024,
    S_F_CHK    = 23'd2048,
    S_I_START  = 23'd4096,
    S_I_RD     = 23'd8192,
    S_I_EVAL   = 23'd16384,
    S_I_RBP    = 23'd32768,
    S_I_RNX    = 23'd65536,
    S_I_RP     = 23'd131072,
    S_I_MERGE  = 23'd262144,
    S_I_LINK   = 23'd524288,
    S_OOM      = 23'd1048576,
    S_BADF     = 23'd2097152,
    S_DONE     = 23'd4194304
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = CMD_NONE;
    case (state_q)
      S_CLEAR: begin
        cmd_o = CMD_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o = CMD_LATCH;
          if (!stat_i.req_free) state_d = S_A_HEAD;
          else if (stat_i.addr_null) state_d = S_DONE;
          else state_d = S_F_RD;
        end
      end
      S_A_HEAD: begin
        cmd_o   = CMD_A_HEAD;
        state_d = S_A_LOAD;
      end
      S_A_LOAD: begin
        cmd_o   = CMD_A_LOAD;
        state_d = S_A_RD;
      end
      S_A_RD: begin
        cmd_o   = CMD_A_RD;
        state_d = S_A_EVAL;
      end
      S_A_EVAL: begin
        cmd_o = CMD_A_EVAL;
        if (stat_i.fit) state_d = stat_i.exact ? S_DONE : S_A_SPLIT;
        else if (stat_i.at_rover) state_d = S_G_SIZE;
        else if (stat_i.guard_over) state_d = S_OOM;
        else state_d = S_A_RD;
      end
      S_A_SPLIT: begin
        cmd_o   = CMD_A_SPLIT;
        state_d = S_DONE;
      end
      S_G_SIZE: begin
        cmd_o   = CMD_G_SIZE;
        state_d = stat_i.taken_full ? S_OOM : S_G_CHECK;
      end
      S_G_CHECK: begin
        cmd_o   = CMD_G_CHECK;
        state_d = stat_i.grow_over ? S_OOM : S_I_START;
      end
      S_A_REHEAD: begin
        cmd_o   = CMD_A_REHEAD;
        state_d = stat_i.guard_over ? S_OOM : S_A_LOAD;
      end
      S_F_RD: begin
        cmd_o   = CMD_F_RD;
        state_d = stat_i.range_bad ? S_BADF : S_F_CHK;
      end
      S_F_CHK: begin
        cmd_o   = CMD_F_CHK;
        state_d = stat_i.hdr_set ? S_I_START : S_BADF;
      end
      S_I_START: begin
        cmd_o   = CMD_I_START;
        state_d = S_I_RD;
      end
      S_I_RD: begin
        cmd_o   = CMD_I_RD;
        state_d = S_I_EVAL;
      end
      S_I_EVAL: begin
        cmd_o = CMD_I_EVAL;
        if (stat_i.ins_stop) state_d = S_I_RBP;
        else if (stat_i.ins_over) state_d = stat_i.is_free ? S_BADF : S_OOM;
        else state_d = S_I_RD;
      end
      S_I_RBP: begin
        cmd_o   = CMD_I_RBP;
        state_d = S_I_RNX;
      end
      S_I_RNX: begin
        cmd_o   = CMD_I_RNX;
        state_d = S_I_RP;
      end
      S_I_RP: begin
        cmd_o   = CMD_I_RP;
        state_d = S_I_MERGE;
      end
      S_I_MERGE: begin
        cmd_o   = CMD_I_MERGE;
        state_d = S_I_LINK;
      end
      S_I_LINK: begin
        cmd_o   = CMD_I_LINK;
        state_d = stat_i.is_free ? S_DONE : S_A_REHEAD;
      end
      S_OOM: begin
        cmd_o   = CMD_OOM;
        state_d = S_DONE;
      end
      S_BADF: begin
        cmd_o   = CMD_BADF;
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o   = CMD_DONE;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

>>> sv/ffa_dpath.sv
module ffa_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ffa_pkg::cmd_e                 cmd_i,
  input  logic                          mode_i,
  input  logic [ffa_pkg::BYTES_W-1:0]   req_bytes_i,
  input  logic [ffa_pkg::ADDR_W-1:0]    block_addr_i,
  input  logic                          cfg_valid_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [ffa_pkg::SIZE_W-1:0]    cfg_data_i,
  output ffa_pkg::stat_t                stat_o,
  output logic [1:0]                    status_o,
  output logic [ffa_pkg::ADDR_W-1:0]    user_addr_o,
  output logic [ffa_pkg::SIZE_W-1:0]    units_in_use_o
);
  import ffa_pkg::*;

  logic [SIZE_W-1:0] bs_mem [MEM_DEPTH];
  logic [ADDR_W-1:0] nf_mem [MEM_DEPTH];
  logic              hd_mem [MEM_DEPTH];

  logic              bs_we, nf_we, hd_we, hd_wd;
  logic [ADDR_W-1:0] bs_wa, nf_wa, hd_wa, bs_ra, nf_ra, hd_ra, nf_wd;
  logic [SIZE_W-1:0] bs_wd, bs_rd;
  logic [ADDR_W-1:0] nf_rd;
  logic              hd_rd;

  // control state
  logic [ADDR_W-1:0] rover_q, rover_d, clr_q, clr_d;
  logic              ready_q, ready_d;
  logic [SIZE_W-1:0] top_q, top_d, taken_q, taken_d, inuse_q, inuse_d;
  logic [SIZE_W-1:0] minc_q, minc_d, maxt_q, maxt_d;
  logic [NEED_W-1:0] guard_q, guard_d, ig_q, ig_d;
  // payload
  logic              mode_q, mode_d, pm_q, pm_d;
  logic [NEED_W-1:0] need_q, need_d, nu_q, nu_d;
  logic [ADDR_W-1:0] bp_q, bp_d, prev_q, prev_d, p_q, p_d, nx_q, nx_d;
  logic [ADDR_W-1:0] nfnx_q, nfnx_d, nfbp_q, nfbp_d, uaddr_q, uaddr_d;
  logic [SIZE_W-1:0] szbp_q, szbp_d, sznx_q, sznx_d, szp_q, szp_d, newbp_q, newbp_d;
  logic [1:0]        status_q, status_d;

  logic [BYTES_W:0]  bytes_rnd;
  logic [NEED_W-1:0] need_in, nu_rnd, nu_c, guard_inc, ig_inc, grow_sum;
  logic [SIZE_W-1:0] split_sz;
  logic              merge_nx, merge_p;

  always_comb begin
    bytes_rnd = {1'b0, req_bytes_i} + (BYTES_W+1)'((1 << LOG_UNIT_BYTES) - 1);
    need_in   = NEED_W'(bytes_rnd >> LOG_UNIT_BYTES) + NEED_W'(1);
    nu_rnd    = NEED_W'((((need_q - NEED_W'(1)) >> LOG_CHUNK) + NEED_W'(1)) << LOG_CHUNK);
    nu_c      = (nu_rnd < {1'b0, minc_q}) ? {1'b0, minc_q} : nu_rnd;
    grow_sum  = {1'b0, top_q} + nu_q;
    guard_inc = guard_q + NEED_W'(1);
    ig_inc    = ig_q + NEED_W'(1);
    split_sz  = bs_rd - SIZE_W'(need_q);
    merge_nx  = ({2'b0, bp_q} + {1'b0, szbp_q}) == {2'b0, nx_q};
    merge_p   = ({2'b0, p_q} + {1'b0, bs_rd}) == {2'b0, bp_q};
  end

  always_comb begin
    stat_o.clr_last   = (clr_q == {ADDR_W{1'b1}});
    stat_o.req_free   = mode_i;
    stat_o.addr_null  = (block_addr_i == '0);
    stat_o.is_free    = mode_q;
    stat_o.fit        = ({1'b0, bs_rd} >= need_q);
    stat_o.exact      = ({1'b0, bs_rd} == need_q);
    stat_o.at_rover   = (p_q == rover_q);
    stat_o.guard_over = (guard_inc > WALK_LIMIT);
    stat_o.taken_full = (taken_q >= maxt_q);
    stat_o.grow_over  = (grow_sum > SPACE_LIMIT);
    stat_o.range_bad  = !ready_q || ({1'b0, bp_q} >= top_q);
    stat_o.hdr_set    = hd_rd;
    stat_o.ins_stop   = ((bp_q > p_q) && (bp_q < nf_rd)) ||
                        ((p_q >= nf_rd) && ((bp_q > p_q) || (bp_q < nf_rd)));
    stat_o.ins_over   = (ig_inc > WALK_LIMIT);
  end

  always_comb begin
    rover_d = rover_q;  clr_d = clr_q;  ready_d = ready_q;
    top_d = top_q;  taken_d = taken_q;  inuse_d = inuse_q;
    minc_d = minc_q;  maxt_d = maxt_q;  guard_d = guard_q;  ig_d = ig_q;
    mode_d = mode_q;  pm_d = pm_q;  need_d = need_q;  nu_d = nu_q;
    bp_d = bp_q;  prev_d = prev_q;  p_d = p_q;  nx_d = nx_q;
    nfnx_d = nfnx_q;  nfbp_d = nfbp_q;  uaddr_d = uaddr_q;
    szbp_d = szbp_q;  sznx_d = sznx_q;  szp_d = szp_q;  newbp_d = newbp_q;
    status_d = status_q;
    bs_we = 1'b0;  bs_wa = '0;  bs_wd = '0;  bs_ra = p_q;
    nf_we = 1'b0;  nf_wa = '0;  nf_wd = '0;  nf_ra = p_q;
    hd_we = 1'b0;  hd_wa = '0;  hd_wd = 1'b0;  hd_ra = bp_q;

    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_MIN_CHUNK) minc_d = cfg_data_i;
      else if (cfg_index_i == CFG_MAX_TOTAL) maxt_d = cfg_data_i;
    end

    case (cmd_i)
      CMD_CLEAR: begin
        hd_we = 1'b1;
        hd_wa = clr_q;
        clr_d = clr_q + ADDR_W'(1);
      end
      CMD_LATCH: begin
        mode_d   = mode_i;
        need_d   = need_in;
        bp_d     = block_addr_i - ADDR_W'(1);
        status_d = ST_OK;
        uaddr_d  = '0;
        guard_d  = '0;
        if (!mode_i && !ready_q) begin
          bs_we   = 1'b1;
          nf_we   = 1'b1;
          rover_d = '0;
          ready_d = 1'b1;
        end
      end
      CMD_A_HEAD: begin
        prev_d = rover_q;
        nf_ra  = rover_q;
      end
      CMD_A_REHEAD: begin
        prev_d  = rover_q;
        nf_ra   = rover_q;
        guard_d = guard_inc;
      end
      CMD_A_LOAD: p_d = nf_rd;
      CMD_A_EVAL: begin
        if ({1'b0, bs_rd} >= need_q) begin
          if ({1'b0, bs_rd} == need_q) begin
            nf_we   = 1'b1;
            nf_wa   = prev_q;
            nf_wd   = nf_rd;
            hd_we   = 1'b1;
            hd_wa   = p_q;
            hd_wd   = 1'b1;
            inuse_d = inuse_q + SIZE_W'(need_q);
            rover_d = prev_q;
            uaddr_d = p_q + ADDR_W'(1);
          end else begin
            bs_we = 1'b1;
            bs_wa = p_q;
            bs_wd = split_sz;
            p_d   = p_q + ADDR_W'(split_sz);
          end
        end else if (p_q != rover_q) begin
          prev_d  = p_q;
          p_d     = nf_rd;
          guard_d = guard_inc;
        end
      end
      CMD_A_SPLIT: begin
        bs_we   = 1'b1;
        bs_wa   = p_q;
        bs_wd   = SIZE_W'(need_q);
        hd_we   = 1'b1;
        hd_wa   = p_q;
        hd_wd   = 1'b1;
        inuse_d = inuse_q + SIZE_W'(need_q);
        rover_d = prev_q;
        uaddr_d = p_q + ADDR_W'(1);
      end
      CMD_G_SIZE: nu_d = nu_c;
      CMD_G_CHECK: begin
        if (grow_sum <= SPACE_LIMIT) begin
          bp_d    = ADDR_W'(top_q);
          top_d   = SIZE_W'(grow_sum);
          taken_d = taken_q + SIZE_W'(nu_q);
          bs_we   = 1'b1;
          bs_wa   = ADDR_W'(top_q);
          bs_wd   = SIZE_W'(nu_q);
          hd_we   = 1'b1;
          hd_wa   = ADDR_W'(top_q);
        end
      end
      CMD_F_RD: begin
        hd_ra = bp_q;
        bs_ra = bp_q;
      end
      CMD_F_CHK: begin
        if (hd_rd) begin
          hd_we   = 1'b1;
          hd_wa   = bp_q;
          inuse_d = inuse_q - bs_rd;
        end
      end
      CMD_I_START: begin
        p_d  = rover_q;
        ig_d = '0;
      end
      CMD_I_RD: nf_ra = p_q;
      CMD_I_EVAL: begin
        nx_d = nf_rd;
        if (!stat_o.ins_stop) begin
          p_d  = nf_rd;
          ig_d = ig_inc;
        end
      end
      CMD_I_RBP: bs_ra = bp_q;
      CMD_I_RNX: begin
        szbp_d = bs_rd;
        bs_ra  = nx_q;
        nf_ra  = nx_q;
      end
      CMD_I_RP: begin
        sznx_d = bs_rd;
        nfnx_d = nf_rd;
        bs_ra  = p_q;
      end
      CMD_I_MERGE: begin
        szp_d   = bs_rd;
        pm_d    = merge_p;
        newbp_d = merge_nx ? (szbp_q + sznx_q) : szbp_q;
        nfbp_d  = merge_nx ? nfnx_q : nx_q;
        bs_we   = 1'b1;
        bs_wa   = bp_q;
        bs_wd   = newbp_d;
        nf_we   = 1'b1;
        nf_wa   = bp_q;
        nf_wd   = nfbp_d;
      end
      CMD_I_LINK: begin
        bs_we   = pm_q;
        bs_wa   = p_q;
        bs_wd   = szp_q + newbp_q;
        nf_we   = 1'b1;
        nf_wa   = p_q;
        nf_wd   = pm_q ? nfbp_q : bp_q;
        rover_d = p_q;
      end
      CMD_OOM: begin
        status_d = ST_NOMEM;
        uaddr_d  = '0;
      end
      CMD_BADF: status_d = ST_BADFREE;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (bs_we) bs_mem[bs_wa] <= bs_wd;
    bs_rd <= bs_mem[bs_ra];
  end

  always_ff @(posedge clk_i) begin
    if (nf_we) nf_mem[nf_wa] <= nf_wd;
    nf_rd <= nf_mem[nf_ra];
  end

  always_ff @(posedge clk_i) begin
    if (hd_we) hd_mem[hd_wa] <= hd_wd;
    hd_rd <= hd_mem[hd_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rover_q <= '0;
      clr_q   <= '0;
      ready_q <= 1'b0;
      top_q   <= SIZE_W'(1);
      taken_q <= '0;
      inuse_q <= '0;
      minc_q  <= SIZE_W'(1024);
      maxt_q  <= SIZE_W'(65536);
      guard_q <= '0;
      ig_q    <= '0;
    end else begin
      rover_q <= rover_d;
      clr_q   <= clr_d;
      ready_q <= ready_d;
      top_q   <= top_d;
      taken_q <= taken_d;
      inuse_q <= inuse_d;
      minc_q  <= minc_d;
      maxt_q  <= maxt_d;
      guard_q <= guard_d;
      ig_q    <= ig_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    pm_q     <= pm_d;
    need_q   <= need_d;
    nu_q     <= nu_d;
    bp_q     <= bp_d;
    prev_q   <= prev_d;
    p_q      <= p_d;
    nx_q     <= nx_d;
    nfnx_q   <= nfnx_d;
    nfbp_q   <= nfbp_d;
    uaddr_q  <= uaddr_d;
    szbp_q   <= szbp_d;
    sznx_q   <= sznx_d;
    szp_q    <= szp_d;
    newbp_q  <= newbp_d;
    status_q <= status_d;
  end

  assign status_o       = status_q;
  assign user_addr_o    = uaddr_q;
  assign units_in_use_o = inuse_q;

endmodule

>>> sv/first_fit_free_list_allocator_core.sv
// First-fit allocator over a 64-byte-unit arena. After reset the block runs a
// pass that clears every header mark, with busy_o high; config writes are
// taken at any time. A request is taken when start_i is high and busy_o low,
// and its result appears on done_o for exactly one cycle with no way to hold
// it off. An allocate walks the free list from the rover, one free block
// visited per step, and on reaching the rover again grows the arena by one
// chunk, which is linked into the list before the walk resumes. A free checks
// range and header mark, then walks the list to link the block in; a null free
// goes straight to its result, and one that fails either check is rejected.
// The next item is taken only once busy_o is low again after the result. Each
// step is paced by the one registered read port on each of the size, link and
// mark memories.
module first_fit_free_list_allocator_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        mode_i,
  input  logic [ffa_pkg::BYTES_W-1:0] req_bytes_i,
  input  logic [ffa_pkg::ADDR_W-1:0]  block_addr_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [ffa_pkg::ADDR_W-1:0]  user_addr_o,
  output logic [ffa_pkg::SIZE_W-1:0]  units_in_use_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [ffa_pkg::SIZE_W-1:0]  cfg_data_i
);
  import ffa_pkg::*;

  cmd_e  cmd;
  stat_t stat;

  assign cfg_ready_o = 1'b1;

  ffa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy_o),
    .done_o (done_o)
  );

  ffa_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .mode_i        (mode_i),
    .req_bytes_i   (req_bytes_i),
    .block_addr_i  (block_addr_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .stat_o        (stat),
    .status_o      (status_o),
    .user_addr_o   (user_addr_o),
    .units_in_use_o(units_in_use_o)
  );

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o) else $error("result strobe while idle");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted item did not go busy");

  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_fail_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (user_addr_o == '0))
    else $error("failed item returned an address");

endmodule

>>> dv/first_fit_free_list_allocator_core_tb.sv
`timescale 1ns / 100ps

module first_fit_free_list_allocator_core_tb;
  import ffa_pkg::*;

  localparam int unsigned HOP_LIMIT = 2 * 65536 + 8;

  typedef struct {
    logic [1:0]        status;
    logic [ADDR_W-1:0] user_addr;
    logic [SIZE_W-1:0] in_use;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [SIZE_W-1:0] blk_size[65536];
    logic [ADDR_W-1:0] blk_link[65536];
    bit                hdr_mark[65536];
    int unsigned       rover, arena_top, taken, in_use;
    bit                list_up;
    int unsigned       min_chunk, max_total;
    alloc_result_t     result_q[$];
    int unsigned       live_q[$];
    int unsigned       fails, n_ok_alloc, n_oom, n_free, n_badfree;

    function new();
      foreach (hdr_mark[i]) hdr_mark[i] = 0;
      rover = 0; list_up = 0; arena_top = 1; taken = 0; in_use = 0;
      min_chunk = 1024; max_total = 65536;
    endfunction

    function void set_reg(logic [1:0] idx, logic [SIZE_W-1:0] val);
      if (idx == CFG_MIN_CHUNK) min_chunk = val;
      else if (idx == CFG_MAX_TOTAL) max_total = val;
    endfunction

    function bit link_in(int unsigned bp);
      int unsigned p, nx, hops;
      p = rover;
      hops = 0;
      while (!(bp > p && bp < blk_link[p])) begin
        nx = blk_link[p];
        if (p >= nx && (bp > p || bp < nx)) break;
        p = nx;
        hops++;
        if (hops > HOP_LIMIT) return 0;
      end
      nx = blk_link[p];
      if (bp + blk_size[bp] == nx) begin
        blk_size[bp] = blk_size[bp] + blk_size[nx];
        blk_link[bp] = blk_link[nx];
      end else begin
        blk_link[bp] = ADDR_W'(nx);
      end
      if (p + blk_size[p] == bp) begin
        blk_size[p] = blk_size[p] + blk_size[bp];
        blk_link[p] = blk_link[bp];
      end else begin
        blk_link[p] = ADDR_W'(bp);
      end
      rover = p;
      return 1;
    endfunction

    function bit grow_arena(int unsigned need);
      int unsigned nu, h;
      if (taken >= max_total) return 0;
      nu = 1024 * ((need - 1) / 1024 + 1);
      if (nu < min_chunk) nu = min_chunk;
      if (arena_top + nu > 65535) return 0;
      h = arena_top;
      arena_top = (arena_top + nu) & 'h1ffff;
      taken = (taken + nu) & 'h1ffff;
      blk_size[h] = SIZE_W'(nu);
      hdr_mark[h] = 0;
      return link_in(h);
    endfunction

    function void note(logic md, logic [BYTES_W-1:0] bytes, logic [ADDR_W-1:0] addr);
      alloc_result_t r;
      int unsigned nunits, prev, p, hops, bp;
      r.status = ST_OK;
      r.user_addr = '0;
      if (md == 1'b0) begin
        nunits = ((bytes + 63) >> LOG_UNIT_BYTES) + 1;
        if (!list_up) begin
          blk_size[0] = '0; blk_link[0] = '0; rover = 0; list_up = 1;
        end
        prev = rover;
        p = blk_link[prev];
        hops = 0;
        forever begin
          if (blk_size[p] >= nunits) begin
            if (blk_size[p] == nunits) begin
              blk_link[prev] = blk_link[p];
            end else begin
              blk_size[p] = SIZE_W'(blk_size[p] - nunits);
              p = p + blk_size[p];
              blk_size[p] = SIZE_W'(nunits);
            end
            hdr_mark[p] = 1;
            in_use = (in_use + nunits) & 'h1ffff;
            rover = prev;
            r.user_addr = ADDR_W'(p + 1);
            break;
          end
          if (p == rover) begin
            if (!grow_arena(nunits)) begin
              r.status = ST_NOMEM;
              break;
            end
            p = rover;
          end
          prev = p;
          p = blk_link[p];
          hops++;
          if (hops > HOP_LIMIT) begin
            r.status = ST_NOMEM;
            break;
          end
        end
        if (r.status == ST_OK) begin
          live_q.push_back(r.user_addr);
          n_ok_alloc++;
        end else begin
          n_oom++;
        end
      end else if (addr != 0) begin
        bp = addr - 1;
        if (!list_up || bp >= arena_top || !hdr_mark[bp]) begin
          r.status = ST_BADFREE;
        end else begin
          hdr_mark[bp] = 0;
          in_use = (in_use - blk_size[bp]) & 'h1ffff;
          if (!link_in(bp)) r.status = ST_BADFREE;
        end
        if (r.status == ST_BADFREE) n_badfree++;
        else n_free++;
      end
      r.in_use = SIZE_W'(in_use);
      result_q.push_back(r);
    endfunction

    function void check(logic [1:0] st, logic [ADDR_W-1:0] ua, logic [SIZE_W-1:0] use_cnt);
      alloc_result_t r;
      if (result_q.size() == 0) begin
        $error("unexpected result: status %0d user_addr %0d", st, ua);
        fails++;
        return;
      end
      r = result_q.pop_front();
      if (st !== r.status) begin
        $error("status: expected %0d actual %0d", r.status, st);
        fails++;
      end
      if (ua !== r.user_addr) begin
        $error("user_addr: expected %0d actual %0d", r.user_addr, ua);
        fails++;
      end
      if (use_cnt !== r.in_use) begin
        $error("units_in_use: expected %0d actual %0d", r.in_use, use_cnt);
        fails++;
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic                mode_i = 1'b0;
  logic [BYTES_W-1:0]  req_bytes_i = '0;
  logic [ADDR_W-1:0]   block_addr_i = '0;
  logic                done_o;
  logic [1:0]          status_o;
  logic [ADDR_W-1:0]   user_addr_o;
  logic [SIZE_W-1:0]   units_in_use_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [1:0]          cfg_index_i = '0;
  logic [SIZE_W-1:0]   cfg_data_i = '0;

  alloc_scoreboard sb = new();
  int unsigned burst_left;

  first_fit_free_list_allocator_core u_top (.*);

  always #5 clk_i = ~clk_i;

  // result of an earlier item is checked before the item taken at this edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) sb.check(status_o, user_addr_o, units_in_use_o);
      if (start_i && !busy_o) sb.note(mode_i, req_bytes_i, block_addr_i);
    end
  end

  initial begin
    #200ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic issue(logic md, logic [BYTES_W-1:0] bytes, logic [ADDR_W-1:0] addr);
    start_i <= 1'b1;
    mode_i <= md;
    req_bytes_i <= bytes;
    block_addr_i <= addr;
    do @(posedge clk_i); while (busy_o);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20)) @(posedge clk_i);
      burst_left = $urandom_range(0, 30);
    end
  endtask

  task automatic alloc_req(logic [BYTES_W-1:0] bytes);
    issue(1'b0, bytes, '0);
  endtask

  task automatic free_live();
    int unsigned k;
    logic [ADDR_W-1:0] a;
    k = $urandom_range(0, sb.live_q.size() - 1);
    a = ADDR_W'(sb.live_q[k]);
    sb.live_q.delete(k);
    issue(1'b1, '0, a);
  endtask

  task automatic wait_empty();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.result_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic drain();
    wait_empty();
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [SIZE_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic random_items(int unsigned count);
    int unsigned r, s;
    logic [BYTES_W-1:0] bytes;
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2) begin
        wait_empty();
      end
      r = $urandom_range(0, 99);
      if (r < 8) begin
        case ($urandom_range(0, 2))
          0: issue(1'b1, BYTES_W'($urandom), '0);
          1: issue(1'b1, BYTES_W'($urandom), ADDR_W'($urandom));
          default: issue(1'b1, BYTES_W'($urandom), ADDR_W'($urandom_range(1, 3000)));
        endcase
      end else if (sb.live_q.size() > 0 && (r >= 55 || sb.live_q.size() > 80)) begin
        free_live();
      end else begin
        s = $urandom_range(0, 99);
        if (s < 80) bytes = BYTES_W'($urandom_range(0, 3000));
        else if (s < 96) bytes = BYTES_W'($urandom_range(0, 70000));
        else bytes = BYTES_W'($urandom);
        alloc_req(bytes);
      end
    end
  endtask

  initial begin
    burst_left = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    issue(1'b1, '0, '0);
    issue(1'b1, '0, 16'd5);
    alloc_req('0);
    alloc_req(23'd1);
    alloc_req(23'd64);
    alloc_req(23'd65);
    issue(1'b1, '0, 16'd1);
    issue(1'b1, '0, 16'hffff);
    issue(1'b1, '0, ADDR_W'(sb.live_q[1]));
    issue(1'b1, '0, ADDR_W'(sb.live_q[1]));
    alloc_req(23'd64);
    alloc_req(23'd4194304);
    alloc_req('1);
    alloc_req(23'd65472);
    alloc_req(23'd200000);
    issue(1'b1, '0, 16'h5555);
    issue(1'b1, '0, 16'haaaa);
    while (sb.live_q.size() > 0) free_live();
    alloc_req(23'd100);
    drain();

    random_items(550);
    drain();
    write_reg(CFG_MIN_CHUNK, 17'd1);
    write_reg(CFG_MAX_TOTAL, 17'd65536);
    random_items(450);
    drain();
    write_reg(CFG_MIN_CHUNK, 17'd65536);
    write_reg(CFG_MAX_TOTAL, 17'd1);
    random_items(250);
    drain();
    write_reg(CFG_MIN_CHUNK, 17'd3000);
    write_reg(CFG_MAX_TOTAL, 17'd40000);
    random_items(400);
    drain();
    write_reg(CFG_MIN_CHUNK, 17'd1024);
    write_reg(CFG_MAX_TOTAL, 17'd65536);
    random_items(250);
    drain();

    $display("covered %0d good allocs, %0d out-of-memory, %0d frees, %0d bad frees",
             sb.n_ok_alloc, sb.n_oom, sb.n_free, sb.n_badfree);
    $display("arena top reached %0d units, %0d units taken", sb.arena_top, sb.taken);
    if (sb.fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/ffa_pkg.sv
sv/ffa_ctrl.sv
sv/ffa_dpath.sv
sv/first_fit_free_list_allocator_core.sv
dv/first_fit_free_list_allocator_core_tb.sv
